// ===== rtl/bba_pkg.sv =====
// Shared types, constants and helper functions of the block bitmap allocator.
package bba_pkg;

	localparam int NUM_BLOCKS = 1024;
	localparam int WORD_W     = 32;
	localparam int NUM_WORDS  = NUM_BLOCKS / WORD_W;
	localparam int WADDR_W    = $clog2(NUM_WORDS);
	localparam int BIT_W      = $clog2(WORD_W);
	localparam int BLK_W      = 10;
	localparam int CNT_W      = 11;
	localparam int CFG_IDX_W  = 1;

	localparam logic [CFG_IDX_W-1:0] CFG_TOTAL    = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_RESERVED = CFG_IDX_W'(1);

	localparam logic [CNT_W-1:0] TOTAL_RST    = CNT_W'(1024);
	localparam logic [CNT_W-1:0] RESERVED_RST = CNT_W'(100);

	typedef enum logic [1:0] {
		OP_INIT  = 2'd0,
		OP_ALLOC = 2'd1,
		OP_FREE  = 2'd2,
		OP_QUERY = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_NOSPACE = 2'd1,
		ST_RANGE   = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_INIT,
		S_SCAN,
		S_ACCESS,
		S_FINISH
	} state_t;

	typedef struct packed {
		logic               en;
		logic [WADDR_W-1:0] addr;
		logic [WORD_W-1:0]  data;
	} map_wr_t;

	// bits of word w whose block number lies below lim
	function automatic logic [WORD_W-1:0] word_mask(input logic [WADDR_W-1:0] w,
			input logic [CNT_W-1:0] lim);
		logic [CNT_W-1:0]  base;
		logic [WORD_W-1:0] m;
		base = CNT_W'({w, BIT_W'(0)});
		if (lim >= base + CNT_W'(WORD_W)) begin
			m = '1;
		end else if (lim <= base) begin
			m = '0;
		end else begin
			m = (WORD_W'(1) << lim[BIT_W-1:0]) - WORD_W'(1);
		end
		return m;
	endfunction

	function automatic logic [BIT_W-1:0] lowest_one(input logic [WORD_W-1:0] w);
		logic [BIT_W-1:0] p;
		p = '0;
		for (int i = WORD_W - 1; i >= 0; i--) begin
			if (w[i]) begin
				p = BIT_W'(i);
			end
		end
		return p;
	endfunction

endpackage

// ===== rtl/bba_req_if.sv =====
// Request channel of the block bitmap allocator.
interface bba_req_if;
	import bba_pkg::*;

	logic             valid;
	logic             ready;
	op_t              operation;
	logic [BLK_W-1:0] target_blk;

	modport source(output valid, output operation, output target_blk, input ready);
	modport sink(input valid, input operation, input target_blk, output ready);
endinterface

// ===== rtl/bba_rsp_if.sv =====
// Result channel of the block bitmap allocator.
interface bba_rsp_if;
	import bba_pkg::*;

	logic             valid;
	logic             ready;
	logic [BLK_W-1:0] block;
	status_t          status;
	logic             block_free;
	logic [CNT_W-1:0] free_count;

	modport source(output valid, output block, output status, output block_free,
		output free_count, input ready);
	modport sink(input valid, input block, input status, input block_free,
		input free_count, output ready);
endinterface

// ===== rtl/block_bitmap_allocator.sv =====
// Block bitmap allocator top level: request sequencer, free counter and result register.
//
// Requests arrive on req (operation, target_blk) and each gives exactly one result on rsp
// (block, status, block_free, free_count). One request is worked on at a time.
// Steps from accept to the finish state, which then loads the result register:
//   init           one map word written per cycle over all 32 words
//   allocate       first-fit scan from word 0, one map word per cycle, to a free bit
//   free, query    one read of the map word; free also writes the word back
//   out of range   straight to the finish state
// The map is a 32 x 32 bit synchronous memory with one read and one write port;
// its single read port serves the first-fit word scan and the free and query reads.
// A new request is taken once the previous one is finished, even while its result still
// waits in the output register. When the receiver stalls, a finished result holds in the
// sequencer until the output register frees up, and no request is taken meanwhile.
// Reset leaves the map clear (rows read as zero until written), the free count at zero,
// the block total at 1024 and the reserved count at 100. Configuration writes go through cfg_we,
// cfg_index (0 block total, 1 reserved count) and cfg_data while idle, kept by the user, unchecked.
module block_bitmap_allocator (
	input  logic                          clk,
	input  logic                          arst_n,
	bba_req_if.sink                       req,
	bba_rsp_if.source                     rsp,
	input  logic                          cfg_we,
	input  logic [bba_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [bba_pkg::CNT_W-1:0]     cfg_data
);
	import bba_pkg::*;

	state_t             state_q, state_d;
	logic [CNT_W-1:0]   total_cfg_q, reserved_cfg_q;
	logic [CNT_W-1:0]   tot_eff, res_eff;
	op_t                op_q;
	logic [BLK_W-1:0]   idx_q;
	logic [CNT_W-1:0]   total_q, res_q;
	logic [WADDR_W-1:0] waddr_q;
	logic [CNT_W-1:0]   counter_q;
	logic [BLK_W-1:0]   rslt_block_q;
	status_t            rslt_status_q;
	logic               rslt_free_q;
	logic               out_valid_q;
	logic [BLK_W-1:0]   out_block_q;
	status_t            out_status_q;
	logic               out_free_q;
	logic [CNT_W-1:0]   out_count_q;

	logic               rd_en;
	logic [WADDR_W-1:0] rd_addr;
	logic [WADDR_W-1:0] rd_word_s1;
	logic [WORD_W-1:0]  rd_data;
	map_wr_t            wr;

	logic [WORD_W-1:0]  cand;
	logic               found;
	logic [BIT_W-1:0]   bitpos;
	logic               scan_last;
	logic [BIT_W-1:0]   acc_bit;
	logic               idx_in_range;
	logic               out_load;

	bba_map_ram u_map (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.wr      (wr),
		.rd_data (rd_data)
	);

	assign tot_eff = (total_cfg_q > CNT_W'(NUM_BLOCKS)) ? CNT_W'(NUM_BLOCKS) : total_cfg_q;
	assign res_eff = (reserved_cfg_q > tot_eff) ? tot_eff : reserved_cfg_q;
	assign idx_in_range = CNT_W'(req.target_blk) < tot_eff;

	assign cand      = ~rd_data & word_mask(rd_word_s1, total_q);
	assign found     = |cand;
	assign bitpos    = lowest_one(cand);
	assign scan_last = CNT_W'({rd_word_s1, BIT_W'(0)}) + CNT_W'(WORD_W) >= total_q;
	assign acc_bit   = idx_q[BIT_W-1:0];
	assign out_load  = (state_q == S_FINISH) && (!out_valid_q || rsp.ready);

	assign req.ready = (state_q == S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		rd_en   = 1'b0;
		rd_addr = waddr_q;
		wr      = '0;
		unique case (state_q)
			S_IDLE: begin
				if (req.valid) begin
					unique case (req.operation)
						OP_INIT: begin
							state_d = S_INIT;
						end
						OP_ALLOC: begin
							rd_en   = 1'b1;
							rd_addr = '0;
							state_d = S_SCAN;
						end
						OP_FREE, OP_QUERY: begin
							if (idx_in_range) begin
								rd_en   = 1'b1;
								rd_addr = req.target_blk[BIT_W +: WADDR_W];
								state_d = S_ACCESS;
							end else begin
								state_d = S_FINISH;
							end
						end
					endcase
				end
			end
			S_INIT: begin
				wr.en   = 1'b1;
				wr.addr = waddr_q;
				wr.data = word_mask(waddr_q, res_q);
				if (waddr_q == WADDR_W'(NUM_WORDS - 1)) begin
					state_d = S_FINISH;
				end
			end
			S_SCAN: begin
				rd_en = 1'b1;
				if (found) begin
					wr.en   = 1'b1;
					wr.addr = rd_word_s1;
					wr.data = rd_data | (WORD_W'(1) << bitpos);
					state_d = S_FINISH;
				end else if (scan_last) begin
					state_d = S_FINISH;
				end
			end
			S_ACCESS: begin
				if (op_q == OP_FREE) begin
					wr.en   = 1'b1;
					wr.addr = idx_q[BIT_W +: WADDR_W];
					wr.data = rd_data & ~(WORD_W'(1) << acc_bit);
				end
				state_d = S_FINISH;
			end
			S_FINISH: begin
				if (out_load) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_word_s1 <= rd_addr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_cfg_q    <= TOTAL_RST;
			reserved_cfg_q <= RESERVED_RST;
		end else if (cfg_we) begin
			if (cfg_index == CFG_TOTAL) begin
				total_cfg_q <= cfg_data;
			end else if (cfg_index == CFG_RESERVED) begin
				reserved_cfg_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			counter_q <= '0;
		end else begin
			unique case (state_q)
				S_INIT: begin
					if (waddr_q == WADDR_W'(NUM_WORDS - 1)) begin
						counter_q <= total_q - res_q;
					end
				end
				S_SCAN: begin
					if (found && counter_q != '0) begin
						counter_q <= counter_q - CNT_W'(1);
					end
				end
				S_ACCESS: begin
					if (op_q == OP_FREE && counter_q < total_q) begin
						counter_q <= counter_q + CNT_W'(1);
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (req.valid) begin
					op_q          <= req.operation;
					idx_q         <= req.target_blk;
					total_q       <= tot_eff;
					res_q         <= res_eff;
					waddr_q       <= (req.operation == OP_ALLOC) ? WADDR_W'(1) : '0;
					rslt_block_q  <= '0;
					rslt_free_q   <= 1'b0;
					rslt_status_q <= ST_OK;
					if ((req.operation == OP_FREE || req.operation == OP_QUERY)
							&& !idx_in_range) begin
						rslt_status_q <= ST_RANGE;
					end
				end
			end
			S_INIT: begin
				waddr_q <= waddr_q + WADDR_W'(1);
			end
			S_SCAN: begin
				waddr_q <= waddr_q + WADDR_W'(1);
				if (found) begin
					rslt_block_q <= BLK_W'({rd_word_s1, bitpos});
				end else if (scan_last) begin
					rslt_status_q <= ST_NOSPACE;
				end
			end
			S_ACCESS: begin
				if (op_q == OP_QUERY) begin
					rslt_free_q <= ~rd_data[acc_bit];
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_block_q  <= rslt_block_q;
			out_status_q <= rslt_status_q;
			out_free_q   <= rslt_free_q;
			out_count_q  <= counter_q;
		end
	end

	assign rsp.valid      = out_valid_q;
	assign rsp.block      = out_block_q;
	assign rsp.status     = out_status_q;
	assign rsp.block_free = out_free_q;
	assign rsp.free_count = out_count_q;

`ifndef ASSERT_OFF
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		counter_q <= CNT_W'(NUM_BLOCKS))
		else $error("free count above map size");

	a_rsp_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_FINISH))
		else $error("result loaded outside finish");

	a_nospace_block: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_status_q == ST_NOSPACE) |-> out_block_q == '0)
		else $error("no-space result with nonzero block");

	a_write_busy: assert property (@(posedge clk) disable iff (!arst_n)
		wr.en |-> (state_q == S_INIT || state_q == S_SCAN || state_q == S_ACCESS))
		else $error("map write while not busy");
`endif

endmodule

// ===== rtl/bba_map_ram.sv =====
// Allocation map memory: one word of block bits per row, rows read as zero until written.
module bba_map_ram (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        rd_en,
	input  logic [bba_pkg::WADDR_W-1:0] rd_addr,
	input  bba_pkg::map_wr_t            wr,
	output logic [bba_pkg::WORD_W-1:0]  rd_data
);
	import bba_pkg::*;

	logic [WORD_W-1:0]    mem [NUM_WORDS];
	logic [WORD_W-1:0]    mem_s1;
	logic [NUM_WORDS-1:0] row_valid_q;
	logic                 row_valid_s1;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		if (rd_en) begin
			mem_s1 <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_valid_q  <= '0;
			row_valid_s1 <= 1'b0;
		end else begin
			if (wr.en) begin
				row_valid_q[wr.addr] <= 1'b1;
			end
			if (rd_en) begin
				row_valid_s1 <= row_valid_q[rd_addr];
			end
		end
	end

	assign rd_data = row_valid_s1 ? mem_s1 : '0;

endmodule

// ===== tb/block_bitmap_allocator_tb.sv =====
// Self-checking testbench for the block bitmap allocator: directed and random requests against a shadow map.
module block_bitmap_allocator_tb;
	import bba_pkg::*;

	localparam int STALL_LIMIT = 2000;
	localparam int HOLD_CYCLES = 300;
	localparam int PHASE_ITEMS = 92;

	typedef struct {
		logic [BLK_W-1:0] block;
		status_t          status;
		logic             block_free;
		logic [CNT_W-1:0] free_count;
	} alloc_result_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CNT_W-1:0] cfg_data;

	bba_req_if req_ch();
	bba_rsp_if rsp_ch();

	block_bitmap_allocator dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	bit [NUM_BLOCKS-1:0] map_copy;
	logic [CNT_W-1:0] free_copy;
	logic [CNT_W-1:0] total_copy;
	logic [CNT_W-1:0] reserved_copy;
	alloc_result_t due_results[$];
	int fault_count;
	int idle_cycles = 0;
	bit no_gaps;
	int hold_asks;

	initial clk = 1'b0;
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic int unsigned managed_blocks();
		return (total_copy > CNT_W'(NUM_BLOCKS)) ? NUM_BLOCKS : int'(total_copy);
	endfunction

	function automatic alloc_result_t apply_request(op_t op, logic [BLK_W-1:0] idx);
		alloc_result_t r;
		int unsigned lim;
		int unsigned res;
		bit found;
		r = '{block: '0, status: ST_OK, block_free: 1'b0, free_count: '0};
		lim = managed_blocks();
		found = 1'b0;
		case (op)
			OP_INIT: begin
				res = (reserved_copy > lim) ? lim : int'(reserved_copy);
				for (int i = 0; i < NUM_BLOCKS; i++)
					map_copy[i] = (i < res);
				free_copy = CNT_W'(lim - res);
			end
			OP_ALLOC: begin
				for (int i = 0; i < lim && !found; i++) begin
					if (!map_copy[i]) begin
						map_copy[i] = 1'b1;
						r.block = BLK_W'(i);
						found = 1'b1;
					end
				end
				if (!found) begin
					r.status = ST_NOSPACE;
				end else if (free_copy != '0) begin
					free_copy = free_copy - CNT_W'(1);
				end
			end
			OP_FREE: begin
				if (idx >= lim) begin
					r.status = ST_RANGE;
				end else begin
					map_copy[idx] = 1'b0;
					if (free_copy < lim)
						free_copy = free_copy + CNT_W'(1);
				end
			end
			default: begin
				if (idx >= lim)
					r.status = ST_RANGE;
				else
					r.block_free = !map_copy[idx];
			end
		endcase
		r.free_count = free_copy;
		return r;
	endfunction

	task automatic flag_mismatch(string msg);
		$display("mismatch at %0t: %s", $realtime, msg);
		fault_count++;
	endtask

	task automatic send_request(op_t op, logic [BLK_W-1:0] idx);
		if (!no_gaps && $urandom_range(0, 4) == 0) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.operation <= op;
		req_ch.target_blk <= idx;
		do @(posedge clk); while (!req_ch.ready);
		due_results.push_back(apply_request(op, idx));
	endtask

	task automatic drain();
		req_ch.valid <= 1'b0;
		while (due_results.size() != 0) @(posedge clk);
		@(posedge clk);
	endtask

	task automatic set_register(logic [CFG_IDX_W-1:0] idx, int unsigned value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= CNT_W'(value);
		@(posedge clk);
		if (idx == CFG_TOTAL)
			total_copy = CNT_W'(value);
		else
			reserved_copy = CNT_W'(value);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic test_before_init();
		send_request(OP_ALLOC, '0);
		send_request(OP_QUERY, '0);
		send_request(OP_FREE, '0);
		send_request(OP_FREE, BLK_W'(1023));
		send_request(OP_QUERY, BLK_W'(1023));
		drain();
	endtask

	task automatic test_reset_settings();
		send_request(OP_INIT, BLK_W'(1023));
		send_request(OP_ALLOC, '0);
		send_request(OP_QUERY, BLK_W'(100));
		send_request(OP_FREE, BLK_W'(100));
		send_request(OP_FREE, BLK_W'(100));
		drain();
	endtask

	task automatic test_reserved_above_total();
		set_register(CFG_TOTAL, 8);
		set_register(CFG_RESERVED, 20);
		send_request(OP_INIT, '0);
		send_request(OP_ALLOC, '0);
		send_request(OP_FREE, BLK_W'(9));
		send_request(OP_QUERY, BLK_W'(9));
		send_request(OP_FREE, BLK_W'(2));
		send_request(OP_ALLOC, '0);
		drain();
	endtask

	task automatic test_count_above_total();
		set_register(CFG_TOTAL, 1024);
		set_register(CFG_RESERVED, 0);
		send_request(OP_INIT, '0);
		drain();
		set_register(CFG_TOTAL, 8);
		send_request(OP_FREE, BLK_W'(3));
		send_request(OP_ALLOC, '0);
		drain();
	endtask

	task automatic test_total_limits();
		set_register(CFG_TOTAL, 0);
		send_request(OP_INIT, '0);
		send_request(OP_ALLOC, '0);
		send_request(OP_QUERY, '0);
		drain();
		set_register(CFG_TOTAL, 1500);
		set_register(CFG_RESERVED, 1024);
		send_request(OP_INIT, '0);
		send_request(OP_ALLOC, '0);
		send_request(OP_FREE, BLK_W'(1023));
		send_request(OP_ALLOC, '0);
		drain();
	endtask

	task automatic run_random_phase(int unsigned tot, int unsigned res, bit do_init, int count);
		int unsigned lim;
		int unsigned roll;
		op_t op;
		logic [BLK_W-1:0] idx;
		set_register(CFG_TOTAL, tot);
		set_register(CFG_RESERVED, res);
		if (do_init)
			send_request(OP_INIT, BLK_W'($urandom_range(0, NUM_BLOCKS - 1)));
		lim = managed_blocks();
		for (int n = 0; n < count; n++) begin
			roll = $urandom_range(0, 99);
			if (roll < 5)
				op = OP_INIT;
			else if (roll < 45)
				op = OP_ALLOC;
			else if (roll < 75)
				op = OP_FREE;
			else
				op = OP_QUERY;
			if (lim != 0 && $urandom_range(0, 3) != 0)
				idx = BLK_W'($urandom_range(0, lim - 1));
			else
				idx = BLK_W'($urandom_range(0, NUM_BLOCKS - 1));
			send_request(op, idx);
		end
		drain();
	endtask

	task automatic test_random_phases();
		int unsigned tot;
		int unsigned res;
		for (int p = 0; p < 11; p++) begin
			case (p)
				0: begin tot = 1; res = 0; end
				1: begin tot = 1; res = 1; end
				2: begin tot = 8; res = 0; end
				3: begin tot = 33; res = 7; end
				4: begin tot = 64; res = 1024; end
				5: begin tot = 1024; res = 0; end
				6: begin tot = 1024; res = 1020; end
				7: begin tot = 200; res = $urandom_range(0, 200); end
				8: begin tot = $urandom_range(1, 1024); res = $urandom_range(0, tot); end
				9: begin tot = 40; res = 40; end
				default: begin tot = $urandom_range(2, 96); res = $urandom_range(0, 8); end
			endcase
			run_random_phase(tot, res, (p % 3) != 2, PHASE_ITEMS);
		end
	endtask

	task automatic test_output_backpressure();
		hold_asks++;
		for (int n = 0; n < 12; n++)
			send_request(($urandom_range(0, 1) != 0) ? OP_ALLOC : OP_QUERY,
				BLK_W'($urandom_range(0, NUM_BLOCKS - 1)));
		drain();
	endtask

	task automatic test_steady_flow();
		no_gaps = 1'b1;
		run_random_phase(1024, 100, 1'b1, PHASE_ITEMS);
	endtask

	initial begin : rsp_ready_drive
		int holds_done;
		holds_done = 0;
		rsp_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_asks != holds_done) begin
				rsp_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				rsp_ch.ready <= 1'b1;
				holds_done++;
			end else if (!no_gaps && $urandom_range(0, 1) != 0) begin
				rsp_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 8)) @(posedge clk);
				rsp_ch.ready <= 1'b1;
			end else begin
				rsp_ch.ready <= 1'b1;
				if (!no_gaps)
					repeat ($urandom_range(0, 30)) @(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		alloc_result_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (due_results.size() == 0) begin
				flag_mismatch("result with no request outstanding");
			end else begin
				want = due_results.pop_front();
				if (rsp_ch.block !== want.block)
					flag_mismatch($sformatf("block got %0d expected %0d",
						rsp_ch.block, want.block));
				if (rsp_ch.status !== want.status)
					flag_mismatch($sformatf("status got %0d expected %0d",
						rsp_ch.status, want.status));
				if (rsp_ch.block_free !== want.block_free)
					flag_mismatch($sformatf("block_free got %0d expected %0d",
						rsp_ch.block_free, want.block_free));
				if (rsp_ch.free_count !== want.free_count)
					flag_mismatch($sformatf("free_count got %0d expected %0d",
						rsp_ch.free_count, want.free_count));
			end
		end
	end

	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	initial begin : watchdog
		@(posedge clk);
		while (idle_cycles < STALL_LIMIT) @(posedge clk);
		$display("tb: failure");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_TOTAL;
		cfg_data = '0;
		req_ch.valid = 1'b0;
		req_ch.operation = OP_INIT;
		req_ch.target_blk = '0;
		map_copy = '0;
		free_copy = '0;
		total_copy = TOTAL_RST;
		reserved_copy = RESERVED_RST;
		fault_count = 0;
		no_gaps = 1'b0;
		hold_asks = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_before_init();
		test_reset_settings();
		test_reserved_above_total();
		test_count_above_total();
		test_total_limits();
		test_random_phases();
		test_output_backpressure();
		test_steady_flow();

		repeat (40) @(posedge clk);
		if (due_results.size() != 0)
			flag_mismatch($sformatf("%0d results never arrived", due_results.size()));
		if (fault_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
